// ----- hw/rtl/via_pkg.sv -----
// Shared types and codes for the interface adapter timer block.
// No dependencies; used by versatile_interface_adapter_timers_top.
package via_pkg;

  localparam int unsigned KindW = 2;
  localparam int unsigned AddrW = 4;
  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 16;
  localparam int unsigned FlagW = 7;

  // Request kinds
  typedef enum logic [KindW-1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_NONE  = 2'd3
  } via_kind_t;

  // Register map, standard order
  typedef enum logic [AddrW-1:0] {
    REG_ORB   = 4'd0,
    REG_ORA   = 4'd1,
    REG_DDRB  = 4'd2,
    REG_DDRA  = 4'd3,
    REG_T1CL  = 4'd4,
    REG_T1CH  = 4'd5,
    REG_T1LL  = 4'd6,
    REG_T1LH  = 4'd7,
    REG_T2CL  = 4'd8,
    REG_T2CH  = 4'd9,
    REG_SR    = 4'd10,
    REG_ACR   = 4'd11,
    REG_PCR   = 4'd12,
    REG_IFR   = 4'd13,
    REG_IER   = 4'd14,
    REG_ORANH = 4'd15
  } via_reg_t;

  // Flag / ACR bit positions
  localparam int unsigned FlagT1Bit   = 6;
  localparam int unsigned FlagT2Bit   = 5;
  localparam int unsigned AcrT1Cont   = 6;
  localparam int unsigned AcrT2Pulse  = 5;

  localparam logic [ByteW-1:0] PortReset  = 8'hFF;
  localparam logic [WordW-1:0] TimerReset = 16'hFFFF;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [AddrW-1:0] reg_addr;
    logic [ByteW-1:0] write_data;
  } via_in_t;

  typedef struct packed {
    logic [ByteW-1:0] read_data;
    logic             irq;
  } via_out_t;

endpackage

// ----- hw/rtl/versatile_interface_adapter_timers_top.sv -----
// Top level of the interface adapter with two 16-bit timers.
// Depends on via_pkg for payload structs, request kinds and register codes.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------
//   in_     | input     | in_valid/in_ready  | via_in_t  (kind, reg_addr, data)
//   out_    | output    | out_valid/out_ready| via_out_t (read_data, irq)
//
// Each request is handled at its accepting edge: the register file and timers
// update then and the response lands in the output register, which sets
// out_valid. Throughput is one request per cycle while out_ready is high.
// in_ready is high whenever the output register is empty or drains this
// cycle, so a stall on out_ready holds at most one response.
// rst_n (synchronous, active low) loads the adapter's reset register values.
module versatile_interface_adapter_timers_top (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  via_pkg::via_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output via_pkg::via_out_t out_data
);

  // Architectural registers
  logic [via_pkg::ByteW-1:0] orb_r, orb_nxt;
  logic [via_pkg::ByteW-1:0] ora_r, ora_nxt;
  logic [via_pkg::ByteW-1:0] ddrb_r, ddrb_nxt;
  logic [via_pkg::ByteW-1:0] ddra_r, ddra_nxt;
  logic [via_pkg::WordW-1:0] t1_latch_r, t1_latch_nxt;
  logic [via_pkg::WordW-1:0] t1_count_r, t1_count_nxt;
  logic [via_pkg::WordW-1:0] t2_latch_r, t2_latch_nxt;
  logic [via_pkg::WordW-1:0] t2_count_r, t2_count_nxt;
  logic                      t1_run_r, t1_run_nxt;
  logic                      t1_armed_r, t1_armed_nxt;
  logic                      t2_run_r, t2_run_nxt;
  logic [via_pkg::ByteW-1:0] sr_r, sr_nxt;
  logic [via_pkg::ByteW-1:0] acr_r, acr_nxt;
  logic [via_pkg::ByteW-1:0] pcr_r, pcr_nxt;
  // IFR bit 7 is always derived, so only bits 6..0 are stored
  logic [via_pkg::FlagW-1:0] ifr_r, ifr_nxt;
  logic [via_pkg::FlagW-1:0] ier_r, ier_nxt;

  // Response register
  logic              out_valid_r, out_valid_nxt;
  via_pkg::via_out_t out_data_r, out_data_nxt;

  logic                      accept;
  logic                      irq_now;
  logic [via_pkg::ByteW-1:0] rd_val;
  via_pkg::via_kind_t        kind;
  via_pkg::via_reg_t         addr;
  logic [via_pkg::ByteW-1:0] wd;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign kind    = via_pkg::via_kind_t'(in_data.kind);
  assign addr    = via_pkg::via_reg_t'(in_data.reg_addr);
  assign wd      = in_data.write_data;
  assign irq_now = |(ifr_r & ier_r);

  // Read mux, no side effects here
  always_comb begin
    unique case (addr)
      via_pkg::REG_ORB:   rd_val = orb_r;
      via_pkg::REG_ORA:   rd_val = ora_r;
      via_pkg::REG_DDRB:  rd_val = ddrb_r;
      via_pkg::REG_DDRA:  rd_val = ddra_r;
      via_pkg::REG_T1CL:  rd_val = t1_count_r[7:0];
      via_pkg::REG_T1CH:  rd_val = t1_count_r[15:8];
      via_pkg::REG_T1LL:  rd_val = t1_latch_r[7:0];
      via_pkg::REG_T1LH:  rd_val = t1_latch_r[15:8];
      via_pkg::REG_T2CL:  rd_val = t2_count_r[7:0];
      via_pkg::REG_T2CH:  rd_val = t2_count_r[15:8];
      via_pkg::REG_SR:    rd_val = sr_r;
      via_pkg::REG_ACR:   rd_val = acr_r;
      via_pkg::REG_PCR:   rd_val = pcr_r;
      via_pkg::REG_IFR:   rd_val = {irq_now, ifr_r};
      via_pkg::REG_IER:   rd_val = {1'b1, ier_r};
      via_pkg::REG_ORANH: rd_val = ora_r;
      default:            rd_val = ora_r;
    endcase
  end

  // State update for one request
  always_comb begin
    orb_nxt      = orb_r;
    ora_nxt      = ora_r;
    ddrb_nxt     = ddrb_r;
    ddra_nxt     = ddra_r;
    t1_latch_nxt = t1_latch_r;
    t1_count_nxt = t1_count_r;
    t2_latch_nxt = t2_latch_r;
    t2_count_nxt = t2_count_r;
    t1_run_nxt   = t1_run_r;
    t1_armed_nxt = t1_armed_r;
    t2_run_nxt   = t2_run_r;
    sr_nxt       = sr_r;
    acr_nxt      = acr_r;
    pcr_nxt      = pcr_r;
    ifr_nxt      = ifr_r;
    ier_nxt      = ier_r;
    out_data_nxt.read_data = '0;

    if (accept) begin
      unique case (kind)
        via_pkg::KIND_READ: begin
          out_data_nxt.read_data = rd_val;
          // counter low-byte reads acknowledge the timer flag
          if (addr == via_pkg::REG_T1CL) ifr_nxt[via_pkg::FlagT1Bit] = 1'b0;
          if (addr == via_pkg::REG_T2CL) ifr_nxt[via_pkg::FlagT2Bit] = 1'b0;
        end
        via_pkg::KIND_WRITE: begin
          unique case (addr)
            via_pkg::REG_ORB:  orb_nxt  = wd;
            via_pkg::REG_ORA:  ora_nxt  = wd;
            via_pkg::REG_DDRB: ddrb_nxt = wd;
            via_pkg::REG_DDRA: ddra_nxt = wd;
            via_pkg::REG_T1CL,
            via_pkg::REG_T1LL: t1_latch_nxt[7:0] = wd;
            via_pkg::REG_T1CH: begin
              t1_latch_nxt[15:8] = wd;
              t1_count_nxt = {wd, t1_latch_r[7:0]};
              t1_run_nxt   = 1'b1;
              t1_armed_nxt = 1'b1;
              ifr_nxt[via_pkg::FlagT1Bit] = 1'b0;
            end
            via_pkg::REG_T1LH: t1_latch_nxt[15:8] = wd;
            via_pkg::REG_T2CL: t2_latch_nxt[7:0]  = wd;
            via_pkg::REG_T2CH: begin
              t2_latch_nxt[15:8] = wd;
              t2_count_nxt = {wd, t2_latch_r[7:0]};
              t2_run_nxt   = 1'b1;
              ifr_nxt[via_pkg::FlagT2Bit] = 1'b0;
            end
            via_pkg::REG_SR:  sr_nxt  = wd;
            via_pkg::REG_ACR: acr_nxt = wd;
            via_pkg::REG_PCR: pcr_nxt = wd;
            via_pkg::REG_IFR: ifr_nxt = ifr_r & ~wd[6:0];
            via_pkg::REG_IER: begin
              // bit 7 picks set or clear
              if (wd[7]) ier_nxt = ier_r | wd[6:0];
              else       ier_nxt = ier_r & ~wd[6:0];
            end
            via_pkg::REG_ORANH: ora_nxt = wd;
            default:            ora_nxt = wd;
          endcase
        end
        via_pkg::KIND_TICK: begin
          if (t1_run_r) begin
            t1_count_nxt = t1_count_r - 16'd1;
            if (t1_count_r == '0) begin
              if (acr_r[via_pkg::AcrT1Cont]) begin
                t1_count_nxt = t1_latch_r;
                ifr_nxt[via_pkg::FlagT1Bit] = 1'b1;
              end else if (t1_armed_r) begin
                // one-shot: flag once per start, keep wrapping
                ifr_nxt[via_pkg::FlagT1Bit] = 1'b1;
                t1_armed_nxt = 1'b0;
              end
            end
          end
          if (t2_run_r && !acr_r[via_pkg::AcrT2Pulse]) begin
            t2_count_nxt = t2_count_r - 16'd1;
            if (t2_count_r == '0) begin
              ifr_nxt[via_pkg::FlagT2Bit] = 1'b1;
              t2_run_nxt = 1'b0;
            end
          end
        end
        via_pkg::KIND_NONE: ;
        default: ;
      endcase
    end

    out_data_nxt.irq = |(ifr_nxt & ier_nxt);
  end

  // Output register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept)         out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orb_r       <= via_pkg::PortReset;
      ora_r       <= via_pkg::PortReset;
      ddrb_r      <= '0;
      ddra_r      <= '0;
      t1_latch_r  <= via_pkg::TimerReset;
      t1_count_r  <= via_pkg::TimerReset;
      t2_latch_r  <= via_pkg::TimerReset;
      t2_count_r  <= via_pkg::TimerReset;
      t1_run_r    <= 1'b0;
      t1_armed_r  <= 1'b0;
      t2_run_r    <= 1'b0;
      sr_r        <= '0;
      acr_r       <= '0;
      pcr_r       <= '0;
      ifr_r       <= '0;
      ier_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      orb_r       <= orb_nxt;
      ora_r       <= ora_nxt;
      ddrb_r      <= ddrb_nxt;
      ddra_r      <= ddra_nxt;
      t1_latch_r  <= t1_latch_nxt;
      t1_count_r  <= t1_count_nxt;
      t2_latch_r  <= t2_latch_nxt;
      t2_count_r  <= t2_count_nxt;
      t1_run_r    <= t1_run_nxt;
      t1_armed_r  <= t1_armed_nxt;
      t2_run_r    <= t2_run_nxt;
      sr_r        <= sr_nxt;
      acr_r       <= acr_nxt;
      pcr_r       <= pcr_nxt;
      ifr_r       <= ifr_nxt;
      ier_r       <= ier_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Response payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule
